>>> rtl/rwts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwts_pkg
// Shared types, codes and constants of the raycast wall texel shader.
// ----------------------------------------------------------------------------
package rwts_pkg;

    // default sizes of the texture store
    localparam int NUM_TEXTURES_DEF = 8;
    localparam int TEX_MAX_SIDE_DEF = 64;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;

    localparam logic [6:0] TEX_WIDTH_RST     = 7'd64;
    localparam logic [6:0] TEX_HEIGHT_RST    = 7'd64;
    localparam logic [9:0] SCREEN_HEIGHT_RST = 10'd480;

    // per-channel halving mask for y-side shading
    localparam logic [23:0] HALF_MASK = 24'h7F7F7F;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_SHADE = 1'b1
    } t_op;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TEX_WIDTH     = 2'd0,
        REG_TEX_HEIGHT    = 2'd1,
        REG_SCREEN_HEIGHT = 2'd2
    } t_reg;

    // fields that ride along the whole pipeline
    typedef struct packed {
        t_op         op;
        logic [2:0]  tex_index;
        logic [11:0] texel_addr;
        logic [23:0] texel_color;
        logic        side;
        logic [9:0]  row;
        logic [9:0]  screen_col;
    } t_item;

    // texture side register as used: zero reads as one, large as the maximum
    function automatic logic [8:0] clamp_side(input logic [6:0] v, input int max_side);
        logic [8:0] res;
        if (v == 7'd0) begin
            res = 9'd1;
        end else if (int'(v) > max_side) begin
            res = 9'(max_side);
        end else begin
            res = {2'b00, v};
        end
        return res;
    endfunction

endpackage

>>> rtl/rwts_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwts_in_if
// Request channel: texel loads and wall pixel shade requests.
// ----------------------------------------------------------------------------
interface rwts_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [2:0]  tex_index;
    logic [11:0] texel_addr;
    logic [23:0] texel_color;
    logic [15:0] wall_frac;
    logic        side;
    logic        dir_x_positive;
    logic        dir_y_negative;
    logic [15:0] slice_height;
    logic [9:0]  row;
    logic [9:0]  screen_col;

    modport source (
        output valid, op, tex_index, texel_addr, texel_color, wall_frac, side,
               dir_x_positive, dir_y_negative, slice_height, row, screen_col,
        input  ready
    );

    modport sink (
        input  valid, op, tex_index, texel_addr, texel_color, wall_frac, side,
               dir_x_positive, dir_y_negative, slice_height, row, screen_col,
        output ready
    );
endinterface

>>> rtl/rwts_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwts_out_if
// Result channel: one shaded pixel per beat.
// ----------------------------------------------------------------------------
interface rwts_out_if;
    logic        valid;
    logic        ready;
    logic [9:0]  out_col;
    logic [9:0]  out_row;
    logic [23:0] color;

    modport source (output valid, out_col, out_row, color, input ready);
    modport sink   (input valid, out_col, out_row, color, output ready);
endinterface

>>> rtl/rwts_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwts_cfg_if
// Register write channel: index and data per beat.
// ----------------------------------------------------------------------------
interface rwts_cfg_if;
    import rwts_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/rwts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwts_ram
// Generic single-port RAM with registered read, held while not enabled.
// ----------------------------------------------------------------------------
module rwts_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32768,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/rwts_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwts_front
// Texture column (with mirroring) and the row numerator d * tex_height.
// Two register stages.
// ----------------------------------------------------------------------------
module rwts_front #(
    parameter int TEX_MAX_SIDE = rwts_pkg::TEX_MAX_SIDE_DEF,
    localparam int SW = $clog2(TEX_MAX_SIDE + 1),
    localparam int TW = $clog2(TEX_MAX_SIDE),
    localparam int NW = 17 + SW
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_valid,
    input  rwts_pkg::t_item i_item,
    input  logic [15:0]     i_wall_frac,
    input  logic            i_dir_x_positive,
    input  logic            i_dir_y_negative,
    input  logic [15:0]     i_slice_height,
    input  logic [SW-1:0]   i_w,
    input  logic [SW-1:0]   i_h,
    input  logic [9:0]      i_screen_height,
    output logic            o_valid,
    output rwts_pkg::t_item o_item,
    output logic [TW-1:0]   o_tx,
    output logic [NW-1:0]   o_num,
    output logic            o_neg,
    output logic [15:0]     o_lh
);
    import rwts_pkg::*;

    logic [16+SW-1:0]   n_frac_prod;
    logic [TW-1:0]      n_tx_raw;
    logic [TW-1:0]      n_tx;
    logic               n_mirror;
    logic [15:0]        n_lh;
    logic signed [17:0] n_d;
    logic [NW-1:0]      n_num;

    logic               r_a_valid;
    t_item              r_a_item;
    logic [TW-1:0]      r_a_tx;
    logic signed [17:0] r_a_d;
    logic [15:0]        r_a_lh;

    logic               r_b_valid;
    t_item              r_b_item;
    logic [TW-1:0]      r_b_tx;
    logic [NW-1:0]      r_b_num;
    logic               r_b_neg;
    logic [15:0]        r_b_lh;

    // stage A: column from the hit fraction, signed row offset d
    always_comb begin
        n_frac_prod = (16+SW)'(i_wall_frac) * (16+SW)'(i_w);
        n_tx_raw    = n_frac_prod[16 +: TW];
        n_mirror    = (!i_item.side && i_dir_x_positive) || (i_item.side && i_dir_y_negative);
        n_tx        = n_mirror ? TW'(i_w - SW'(1) - SW'(n_tx_raw)) : n_tx_raw;
        n_lh        = (i_slice_height == 16'd0) ? 16'd1 : i_slice_height;
        n_d         = signed'({7'd0, i_item.row, 1'b0}) - signed'({8'd0, i_screen_height})
                    + signed'({2'd0, n_lh});
    end

    // stage B: numerator; a negative d always ends on texture row zero
    always_comb begin
        n_num = NW'(r_a_d[16:0]) * NW'(i_h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_adv) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_item <= i_item;
            r_a_tx   <= n_tx;
            r_a_d    <= n_d;
            r_a_lh   <= n_lh;
            r_b_item <= r_a_item;
            r_b_tx   <= r_a_tx;
            r_b_num  <= n_num;
            r_b_neg  <= r_a_d[17];
            r_b_lh   <= r_a_lh;
        end
    end

    assign o_valid = r_b_valid;
    assign o_item  = r_b_item;
    assign o_tx    = r_b_tx;
    assign o_num   = r_b_num;
    assign o_neg   = r_b_neg;
    assign o_lh    = r_b_lh;
endmodule

>>> rtl/rwts_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwts_div
// Pipelined restoring divider, one quotient bit per stage. Quotients at or
// above 2^QW are flagged as saturated in the first stage.
// ----------------------------------------------------------------------------
module rwts_div #(
    parameter int TEX_MAX_SIDE = rwts_pkg::TEX_MAX_SIDE_DEF,
    localparam int SW = $clog2(TEX_MAX_SIDE + 1),
    localparam int TW = $clog2(TEX_MAX_SIDE),
    localparam int QW = TW + 1,
    localparam int NW = 17 + SW,
    localparam int CW = (NW > 17 + QW) ? NW : 17 + QW
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_valid,
    input  rwts_pkg::t_item i_item,
    input  logic [TW-1:0]   i_tx,
    input  logic [NW-1:0]   i_num,
    input  logic            i_neg,
    input  logic [15:0]     i_lh,
    output logic            o_valid,
    output rwts_pkg::t_item o_item,
    output logic [TW-1:0]   o_tx,
    output logic [QW-1:0]   o_q,
    output logic            o_sat,
    output logic            o_neg
);
    import rwts_pkg::*;

    logic          r_v    [QW];
    t_item         r_item [QW];
    logic [TW-1:0] r_tx   [QW];
    logic [CW-1:0] r_rem  [QW];
    logic [QW-1:0] r_q    [QW];
    logic          r_sat  [QW];
    logic          r_neg  [QW];
    logic [15:0]   r_lh   [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic          p_v;
        t_item         p_item;
        logic [TW-1:0] p_tx;
        logic [CW-1:0] p_rem;
        logic [QW-1:0] p_q;
        logic          p_sat;
        logic          p_neg;
        logic [15:0]   p_lh;
        logic [CW-1:0] n_div;
        logic          n_bit;
        logic [CW-1:0] n_rem;
        logic [QW-1:0] n_q;

        if (k == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_item = i_item;
            assign p_tx   = i_tx;
            assign p_rem  = CW'(i_num);
            assign p_q    = '0;
            // quotient too large for QW bits: row saturates anyway
            assign p_sat  = CW'(i_num) >= (CW'(i_lh) << QW);
            assign p_neg  = i_neg;
            assign p_lh   = i_lh;
        end else begin : g_next
            assign p_v    = r_v[k-1];
            assign p_item = r_item[k-1];
            assign p_tx   = r_tx[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_q    = r_q[k-1];
            assign p_sat  = r_sat[k-1];
            assign p_neg  = r_neg[k-1];
            assign p_lh   = r_lh[k-1];
        end

        // trial subtract of the shifted divisor
        always_comb begin
            n_div = CW'(p_lh) << (QW - 1 - k);
            n_bit = p_rem >= n_div;
            n_rem = n_bit ? p_rem - n_div : p_rem;
            n_q   = p_q;
            n_q[QW-1-k] = n_bit;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_adv) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_item[k] <= p_item;
                r_tx[k]   <= p_tx;
                r_rem[k]  <= n_rem;
                r_q[k]    <= n_q;
                r_sat[k]  <= p_sat;
                r_neg[k]  <= p_neg;
                r_lh[k]   <= p_lh;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_item  = r_item[QW-1];
    assign o_tx    = r_tx[QW-1];
    assign o_q     = r_q[QW-1];
    assign o_sat   = r_sat[QW-1];
    assign o_neg   = r_neg[QW-1];

    // after the first step the remainder is below the first step's shifted divisor
    a_first_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] && !r_sat[0] |-> r_rem[0] < (CW'(r_lh[0]) << (QW - 1)))
        else $error("divider first step left remainder too large");

    // finished division leaves a remainder below the divisor
    a_final_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[QW-1] && !r_sat[QW-1] && !r_neg[QW-1] |-> r_rem[QW-1] < CW'(r_lh[QW-1]))
        else $error("divider remainder not below line height");
endmodule

>>> rtl/rwts_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwts_back
// Row saturation, texel address, texture store access and y-side shading,
// ending in the output register.
// ----------------------------------------------------------------------------
module rwts_back #(
    parameter int NUM_TEXTURES = rwts_pkg::NUM_TEXTURES_DEF,
    parameter int TEX_MAX_SIDE = rwts_pkg::TEX_MAX_SIDE_DEF,
    localparam int SW    = $clog2(TEX_MAX_SIDE + 1),
    localparam int TW    = $clog2(TEX_MAX_SIDE),
    localparam int QW    = TW + 1,
    localparam int AREA  = TEX_MAX_SIDE * TEX_MAX_SIDE,
    localparam int DEPTH = NUM_TEXTURES * AREA,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_valid,
    input  rwts_pkg::t_item i_item,
    input  logic [TW-1:0]   i_tx,
    input  logic [QW-1:0]   i_q,
    input  logic            i_sat,
    input  logic            i_neg,
    input  logic [SW-1:0]   i_w,
    input  logic [SW-1:0]   i_h,
    output logic            o_valid,
    output logic [9:0]      o_col,
    output logic [9:0]      o_row,
    output logic [23:0]     o_color
);
    import rwts_pkg::*;

    logic [TW-1:0]    n_qh;
    logic [SW-1:0]    n_hmax;
    logic [TW-1:0]    n_ty;
    logic [SW+TW-1:0] n_wty;
    logic             n_in_range;

    logic             r_c_valid;
    t_item            r_c_item;
    logic [TW-1:0]    r_c_tx;
    logic [SW+TW-1:0] r_c_wty;
    logic             r_c_in_range;

    logic [31:0]      n_tex_base;
    logic [31:0]      n_shade_off;
    logic             n_we;
    logic [AW-1:0]    n_addr;
    logic [23:0]      w_texel;

    logic             r_d_valid;
    t_item            r_d_item;
    logic             r_d_in_range;

    logic [23:0]      n_base_color;
    logic [23:0]      n_color;

    logic             r_o_valid;
    logic [9:0]       r_o_col;
    logic [9:0]       r_o_row;
    logic [23:0]      r_o_color;

    // stage C: texture row = quotient / 2, saturated to 0..H-1
    always_comb begin
        n_qh   = i_q[QW-1:1];
        n_hmax = i_h - SW'(1);
        if (i_neg) begin
            n_ty = '0;
        end else if (i_sat || SW'(n_qh) >= n_hmax) begin
            n_ty = TW'(n_hmax);
        end else begin
            n_ty = n_qh;
        end
        n_wty      = (SW+TW)'(i_w) * (SW+TW)'(n_ty);
        n_in_range = 32'(i_item.tex_index) < 32'(NUM_TEXTURES);
    end

    // stage D: store address; loads write, shades read, in pipeline order
    always_comb begin
        n_tex_base  = 32'(r_c_item.tex_index) * 32'(AREA);
        n_shade_off = 32'(r_c_wty) + 32'(r_c_tx);
        n_we        = r_c_valid && (r_c_item.op == OP_LOAD) && r_c_in_range
                   && (32'(r_c_item.texel_addr) < 32'(AREA));
        n_addr      = AW'(n_tex_base + ((r_c_item.op == OP_LOAD) ?
                                        32'(r_c_item.texel_addr) : n_shade_off));
    end

    rwts_ram #(
        .WIDTH (24),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (i_adv),
        .i_we    (n_we),
        .i_addr  (n_addr),
        .i_wdata (r_c_item.texel_color),
        .o_rdata (w_texel)
    );

    // output: missing texture gives black, y sides are halved
    always_comb begin
        n_base_color = r_d_in_range ? w_texel : '0;
        n_color      = r_d_item.side ? ((n_base_color >> 1) & HALF_MASK) : n_base_color;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (i_adv) begin
            r_c_valid <= i_valid;
            r_d_valid <= r_c_valid;
            r_o_valid <= r_d_valid && (r_d_item.op == OP_SHADE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_c_item     <= i_item;
            r_c_tx       <= i_tx;
            r_c_wty      <= n_wty;
            r_c_in_range <= n_in_range;
            r_d_item     <= r_c_item;
            r_d_in_range <= r_c_in_range;
            r_o_col      <= r_d_item.screen_col;
            r_o_row      <= r_d_item.row;
            r_o_color    <= n_color;
        end
    end

    assign o_valid = r_o_valid;
    assign o_col   = r_o_col;
    assign o_row   = r_o_row;
    assign o_color = r_o_color;

    // a shaded texel always lies inside its own texture
    a_in_texture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid && (r_c_item.op == OP_SHADE) |-> (32'(r_c_wty) + 32'(r_c_tx)) < 32'(AREA))
        else $error("shade offset outside texture area");
endmodule

>>> rtl/raycast_wall_texel_shader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raycast_wall_texel_shader
// Wall texture mapping for a raycaster: texel loads and per-pixel shading.
// ----------------------------------------------------------------------------
// Takes one beat per clock unless held, loads and shades alike, and gives one
// result per shade beat. The pipeline registers are two stages for the column
// and numerator, one stage per quotient bit of the row divider, then row
// saturation, the texture store read and the output register. The whole
// pipeline moves as one: it holds only while a result waits at the output.
// Loads and shades share the single store port at one stage, so a shade sees
// every load accepted before it. The user must write registers only while the
// block is idle; the block itself does not enforce it. The store has no
// clearing pass and texels must be loaded before they are sampled.
// ----------------------------------------------------------------------------
module raycast_wall_texel_shader #(
    parameter int NUM_TEXTURES = rwts_pkg::NUM_TEXTURES_DEF,
    parameter int TEX_MAX_SIDE = rwts_pkg::TEX_MAX_SIDE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rwts_cfg_if.sink   i_cfg,
    rwts_in_if.sink    i_in,
    rwts_out_if.source o_out
);
    import rwts_pkg::*;

    localparam int SW = $clog2(TEX_MAX_SIDE + 1);
    localparam int TW = $clog2(TEX_MAX_SIDE);
    localparam int QW = TW + 1;
    localparam int NW = 17 + SW;

    logic [6:0]    r_tex_width;
    logic [6:0]    r_tex_height;
    logic [9:0]    r_screen_height;
    logic [SW-1:0] tex_w;
    logic [SW-1:0] tex_h;
    logic          adv;
    t_item         in_item;

    logic          f_valid;
    t_item         f_item;
    logic [TW-1:0] f_tx;
    logic [NW-1:0] f_num;
    logic          f_neg;
    logic [15:0]   f_lh;

    logic          d_valid;
    t_item         d_item;
    logic [TW-1:0] d_tx;
    logic [QW-1:0] d_q;
    logic          d_sat;
    logic          d_neg;

    logic          b_valid;
    logic [9:0]    b_col;
    logic [9:0]    b_row;
    logic [23:0]   b_color;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width     <= TEX_WIDTH_RST;
            r_tex_height    <= TEX_HEIGHT_RST;
            r_screen_height <= SCREEN_HEIGHT_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_TEX_WIDTH:     r_tex_width     <= i_cfg.data[6:0];
                REG_TEX_HEIGHT:    r_tex_height    <= i_cfg.data[6:0];
                REG_SCREEN_HEIGHT: r_screen_height <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign tex_w = SW'(clamp_side(r_tex_width, TEX_MAX_SIDE));
    assign tex_h = SW'(clamp_side(r_tex_height, TEX_MAX_SIDE));

    // pipeline moves whenever the output register is free or being drained
    assign adv        = !b_valid || o_out.ready;
    assign i_in.ready = adv;

    always_comb begin
        in_item.op          = t_op'(i_in.op);
        in_item.tex_index   = i_in.tex_index;
        in_item.texel_addr  = i_in.texel_addr;
        in_item.texel_color = i_in.texel_color;
        in_item.side        = i_in.side;
        in_item.row         = i_in.row;
        in_item.screen_col  = i_in.screen_col;
    end

    rwts_front #(
        .TEX_MAX_SIDE (TEX_MAX_SIDE)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_adv            (adv),
        .i_valid          (i_in.valid),
        .i_item           (in_item),
        .i_wall_frac      (i_in.wall_frac),
        .i_dir_x_positive (i_in.dir_x_positive),
        .i_dir_y_negative (i_in.dir_y_negative),
        .i_slice_height   (i_in.slice_height),
        .i_w              (tex_w),
        .i_h              (tex_h),
        .i_screen_height  (r_screen_height),
        .o_valid          (f_valid),
        .o_item           (f_item),
        .o_tx             (f_tx),
        .o_num            (f_num),
        .o_neg            (f_neg),
        .o_lh             (f_lh)
    );

    rwts_div #(
        .TEX_MAX_SIDE (TEX_MAX_SIDE)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (f_valid),
        .i_item  (f_item),
        .i_tx    (f_tx),
        .i_num   (f_num),
        .i_neg   (f_neg),
        .i_lh    (f_lh),
        .o_valid (d_valid),
        .o_item  (d_item),
        .o_tx    (d_tx),
        .o_q     (d_q),
        .o_sat   (d_sat),
        .o_neg   (d_neg)
    );

    rwts_back #(
        .NUM_TEXTURES (NUM_TEXTURES),
        .TEX_MAX_SIDE (TEX_MAX_SIDE)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (d_valid),
        .i_item  (d_item),
        .i_tx    (d_tx),
        .i_q     (d_q),
        .i_sat   (d_sat),
        .i_neg   (d_neg),
        .i_w     (tex_w),
        .i_h     (tex_h),
        .o_valid (b_valid),
        .o_col   (b_col),
        .o_row   (b_row),
        .o_color (b_color)
    );

    assign o_out.valid   = b_valid;
    assign o_out.out_col = b_col;
    assign o_out.out_row = b_row;
    assign o_out.color   = b_color;

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("result pending after reset");

    // input is held off only by a result waiting at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_out.valid && !o_out.ready)
        else $error("input stalled without output back-pressure");

    // clamped texture sizes stay within 1..TEX_MAX_SIDE
    a_side_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tex_w != '0 && tex_h != '0 && 32'(tex_w) <= 32'(TEX_MAX_SIDE)
        && 32'(tex_h) <= 32'(TEX_MAX_SIDE))
        else $error("texture side out of range");
endmodule

>>> dv/raycast_wall_texel_shader_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raycast_wall_texel_shader_tb
// Self-checking bench for the raycast wall texel shader.
// ----------------------------------------------------------------------------
// Loads texels and shades wall pixels through the request channel, with
// random idle cycles on the request side and random back-pressure on the
// result side. A behavioural model of the texel mapping, kept in step with
// every accepted request beat, predicts each shaded pixel. Results are
// compared in order. A short table of hand-picked beats comes first, then
// random traffic under a series of texture and screen geometries, including
// zero, oversized and masked register values. A shade never reads a texel
// that has not been loaded: any missing texel is loaded just before the shade.
// ----------------------------------------------------------------------------
module raycast_wall_texel_shader_tb;
    import rwts_pkg::*;

    localparam int NUM_TEX      = NUM_TEXTURES_DEF;
    localparam int TEX_AREA     = TEX_MAX_SIDE_DEF * TEX_MAX_SIDE_DEF;
    localparam int STORE_DEPTH  = NUM_TEX * TEX_AREA;
    localparam int DRAIN_CYCLES = 24;        // twice the pipeline depth
    localparam int CYCLE_LIMIT  = 600000;
    localparam int BEATS_PER_PHASE = 60;
    localparam int NUM_PHASES   = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        t_op         op;
        logic [2:0]  tex;
        logic [11:0] addr;
        logic [23:0] texel;
        logic [15:0] frac;
        logic        side;
        logic        dxp;
        logic        dyn;
        logic [15:0] lh;
        logic [9:0]  row;
        logic [9:0]  col;
    } t_req;

    typedef struct {
        logic [9:0]  col;
        logic [9:0]  row;
        logic [23:0] color;
    } t_pixel;

    // hand-picked beat, with a typed colour where the answer is obvious
    typedef struct {
        t_req        req;
        bit          typed;
        logic [23:0] color;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    rwts_cfg_if cfg_if ();
    rwts_in_if  req_if ();
    rwts_out_if pix_if ();

    raycast_wall_texel_shader u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (req_if),
        .o_out   (pix_if)
    );

    // shadow of the texture store and of the geometry registers
    logic [23:0] tex_shadow [STORE_DEPTH];
    bit          tex_loaded [STORE_DEPTH];
    int          loaded_offsets [$];
    logic [6:0]  geo_w;
    logic [6:0]  geo_h;
    logic [9:0]  geo_sh;

    t_pixel pending_pixels [$];
    t_row   stim_rows [$];

    int errors;
    int cycles;
    int n_loads;
    int n_shades;
    int n_pixels;
    int n_dark;
    int n_geometries;
    int src_mode;
    int sink_mode;
    int stall_left;

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("raycast_wall_texel_shader_tb: timeout after %0d cycles", cycles);
            $display("raycast_wall_texel_shader_tb: done, errors");
            $finish;
        end
    end

    task automatic note_mismatch(input string msg);
        errors++;
        if (errors <= 10) begin
            $display("MISMATCH @%0t: %s", $realtime, msg);
        end
    endtask

    // size register as used: zero reads as one, anything over the maximum clips
    function automatic int side_used(input logic [6:0] v);
        if (v == 7'd0) begin
            return 1;
        end
        if (int'(v) > TEX_MAX_SIDE_DEF) begin
            return TEX_MAX_SIDE_DEF;
        end
        return int'(v);
    endfunction

    // store entry that a shade beat samples under the current geometry
    function automatic int texel_offset(input t_req r);
        int     w;
        int     h;
        int     tx;
        longint lh;
        longint d;
        longint t;
        longint ty;
        w  = side_used(geo_w);
        h  = side_used(geo_h);
        lh = (r.lh == 16'd0) ? 1 : longint'(r.lh);
        tx = (int'(r.frac) * w) >> 16;
        // mirror for east-facing x sides and north-facing y sides
        if ((!r.side && r.dxp) || (r.side && r.dyn)) begin
            tx = w - 1 - tx;
        end
        d  = 2 * longint'(r.row) - longint'(geo_sh) + lh;
        t  = (d * h) / lh;
        ty = t / 2;
        if (ty < 0) begin
            ty = 0;
        end
        if (ty > h - 1) begin
            ty = h - 1;
        end
        return int'(r.tex) * TEX_AREA + w * int'(ty) + tx;
    endfunction

    function automatic t_pixel shade_pixel(input t_req r);
        t_pixel px;
        px.col   = r.col;
        px.row   = r.row;
        px.color = '0;
        if (int'(r.tex) < NUM_TEX) begin
            px.color = tex_shadow[texel_offset(r)];
        end
        // y sides are drawn at half brightness
        if (r.side) begin
            px.color = (px.color >> 1) & HALF_MASK;
        end
        return px;
    endfunction

    function automatic t_req mk_load(input logic [2:0] tex, input logic [11:0] addr,
                                     input logic [23:0] texel);
        t_req r;
        r.op    = OP_LOAD;
        r.tex   = tex;
        r.addr  = addr;
        r.texel = texel;
        // shade-only fields carry noise on loads
        r.frac  = 16'($urandom);
        r.side  = 1'($urandom);
        r.dxp   = 1'($urandom);
        r.dyn   = 1'($urandom);
        r.lh    = 16'($urandom);
        r.row   = 10'($urandom);
        r.col   = 10'($urandom);
        return r;
    endfunction

    function automatic t_req mk_shade(input logic [2:0] tex, input logic [15:0] frac,
                                      input logic side, input logic dxp, input logic dyn,
                                      input logic [15:0] lh, input logic [9:0] row,
                                      input logic [9:0] col);
        t_req r;
        r.op    = OP_SHADE;
        r.tex   = tex;
        r.addr  = 12'($urandom);
        r.texel = 24'($urandom);
        r.frac  = frac;
        r.side  = side;
        r.dxp   = dxp;
        r.dyn   = dyn;
        r.lh    = lh;
        r.row   = row;
        r.col   = col;
        return r;
    endfunction

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap(input int mode);
        int p;
        if (mode == 0) begin
            return 0;
        end
        p = $urandom_range(0, 99);
        if (p < 65) begin
            return 0;
        end
        if (p < 94) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // one request beat; valid is left high for a back-to-back follower
    task automatic send_beat(input t_req r, input bit typed, input logic [23:0] color);
        t_pixel px;
        int     off;
        req_if.valid          <= 1'b1;
        req_if.op             <= r.op;
        req_if.tex_index      <= r.tex;
        req_if.texel_addr     <= r.addr;
        req_if.texel_color    <= r.texel;
        req_if.wall_frac      <= r.frac;
        req_if.side           <= r.side;
        req_if.dir_x_positive <= r.dxp;
        req_if.dir_y_negative <= r.dyn;
        req_if.slice_height   <= r.lh;
        req_if.row            <= r.row;
        req_if.screen_col     <= r.col;
        do @(posedge i_clk); while (!req_if.ready);
        if (r.op == OP_LOAD) begin
            n_loads++;
            if (int'(r.tex) < NUM_TEX && int'(r.addr) < TEX_AREA) begin
                off = int'(r.tex) * TEX_AREA + int'(r.addr);
                tex_shadow[off] = r.texel;
                if (!tex_loaded[off]) begin
                    tex_loaded[off] = 1'b1;
                    loaded_offsets.push_back(off);
                end
            end
        end else begin
            n_shades++;
            if (r.side) begin
                n_dark++;
            end
            px = shade_pixel(r);
            if (typed) begin
                px.color = color;
            end
            pending_pixels.push_back(px);
        end
    endtask

    task automatic idle_gap();
        int n;
        n = pick_gap(src_mode);
        if (n > 0) begin
            req_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // a shade of a texel never loaded gets that texel loaded first
    task automatic issue(input t_req r, input bit typed, input logic [23:0] color);
        int off;
        if (r.op == OP_SHADE) begin
            off = texel_offset(r);
            if (!tex_loaded[off]) begin
                send_beat(mk_load(3'(off / TEX_AREA), 12'(off % TEX_AREA), 24'($urandom)),
                          1'b0, '0);
                idle_gap();
            end
        end
        send_beat(r, typed, color);
        idle_gap();
    endtask

    task automatic random_beat();
        t_req   r;
        int     p;
        int     off;
        int     lh_used;
        int     lo;
        int     hi;
        logic [15:0] lh;
        p = $urandom_range(0, 99);
        if (p < 25) begin
            r = mk_load(3'($urandom), 12'($urandom), 24'($urandom));
            // some loads overwrite texels already in use
            if (p < 10 && loaded_offsets.size() != 0) begin
                off    = loaded_offsets[$urandom_range(0, loaded_offsets.size() - 1)];
                r.tex  = 3'(off / TEX_AREA);
                r.addr = 12'(off % TEX_AREA);
            end
        end else begin
            case ($urandom_range(0, 9))
                0:       lh = 16'd0;
                1:       lh = 16'($urandom);
                2, 3, 4: lh = 16'($urandom_range(1, 64));
                default: lh = 16'($urandom_range(65, 1200));
            endcase
            r = mk_shade(3'($urandom), 16'($urandom), 1'($urandom), 1'($urandom),
                         1'($urandom), lh, 10'($urandom), 10'($urandom));
            // about half the rows are drawn from the visible part of the slice
            if ($urandom_range(0, 1) == 0) begin
                lh_used = (lh == 16'd0) ? 1 : int'(lh);
                lo = (int'(geo_sh) - lh_used) / 2;
                hi = (int'(geo_sh) + lh_used) / 2;
                if (lo < 0) begin
                    lo = 0;
                end
                if (hi > 1023) begin
                    hi = 1023;
                end
                r.row = 10'($urandom_range(lo, hi));
            end
        end
        issue(r, 1'b0, '0);
    endtask

    // hold back requests until every pixel is out and the pipeline is empty
    task automatic drain();
        req_if.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [9:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            REG_TEX_WIDTH:     geo_w  = val[6:0];
            REG_TEX_HEIGHT:    geo_h  = val[6:0];
            REG_SCREEN_HEIGHT: geo_sh = val;
            default: ;
        endcase
    endtask

    task automatic set_geometry(input logic [9:0] w, input logic [9:0] h,
                                input logic [9:0] sh, input bit poke_unused);
        write_reg(REG_TEX_WIDTH, w);
        if (poke_unused) begin
            write_reg(REG_UNUSED, 10'($urandom));
        end
        write_reg(REG_TEX_HEIGHT, h);
        write_reg(REG_SCREEN_HEIGHT, sh);
        cfg_if.valid <= 1'b0;
        n_geometries++;
        @(posedge i_clk);
    endtask

    // result side: check each beat, then pick the next stall
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && pix_if.valid && pix_if.ready) begin
            n_pixels++;
            if (pending_pixels.size() == 0) begin
                note_mismatch($sformatf("unexpected pixel col=%0d row=%0d color=%06h",
                                        pix_if.out_col, pix_if.out_row, pix_if.color));
            end else begin
                want = pending_pixels.pop_front();
                if (pix_if.out_col !== want.col) begin
                    note_mismatch($sformatf("out_col exp %0d got %0d", want.col,
                                            pix_if.out_col));
                end
                if (pix_if.out_row !== want.row) begin
                    note_mismatch($sformatf("out_row exp %0d got %0d", want.row,
                                            pix_if.out_row));
                end
                if (pix_if.color !== want.color) begin
                    note_mismatch($sformatf("color exp %06h got %06h (col %0d row %0d)",
                                            want.color, pix_if.color, want.col, want.row));
                end
            end
        end
        // swap between steady and stalling stretches now and then
        if ($urandom_range(0, 299) == 0) begin
            sink_mode = (sink_mode == 0) ? 1 : 0;
        end
        if (stall_left == 0) begin
            stall_left = pick_gap(sink_mode);
        end
        if (stall_left > 0) begin
            stall_left--;
            pix_if.ready <= 1'b0;
        end else begin
            pix_if.ready <= 1'b1;
        end
    end

    // stimulus
    initial begin
        logic [9:0] gw;
        logic [9:0] gh;
        logic [9:0] gsh;

        errors       = 0;
        cycles       = 0;
        n_loads      = 0;
        n_shades     = 0;
        n_pixels     = 0;
        n_dark       = 0;
        n_geometries = 0;
        sink_mode    = 1;
        stall_left   = 0;
        src_mode     = 1;
        geo_w        = TEX_WIDTH_RST;
        geo_h        = TEX_HEIGHT_RST;
        geo_sh       = SCREEN_HEIGHT_RST;

        i_rst_n      = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data  = '0;
        req_if.valid = 1'b0;
        req_if.op    = OP_LOAD;
        req_if.tex_index      = '0;
        req_if.texel_addr     = '0;
        req_if.texel_color    = '0;
        req_if.wall_frac      = '0;
        req_if.side           = 1'b0;
        req_if.dir_x_positive = 1'b0;
        req_if.dir_y_negative = 1'b0;
        req_if.slice_height   = '0;
        req_if.row            = '0;
        req_if.screen_col     = '0;
        pix_if.ready = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // hand-picked beats under the reset geometry (64 x 64, screen 480)
        stim_rows.push_back('{mk_load(3'd0, 12'd0, 24'hFFFFFF), 1'b0, '0});
        stim_rows.push_back('{mk_load(3'd7, 12'd4095, 24'h000000), 1'b0, '0});
        stim_rows.push_back('{mk_load(3'd1, 12'd63, 24'hABCDEF), 1'b0, '0});
        stim_rows.push_back('{mk_load(3'd3, 12'd2048, 24'h5A5AA5), 1'b0, '0});
        // top-left texel, plain and darkened; x mirror flag ignored on y sides
        stim_rows.push_back('{mk_shade(3'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 16'd1, 10'd0,
                                       10'd0), 1'b1, 24'hFFFFFF});
        stim_rows.push_back('{mk_shade(3'd0, 16'h0000, 1'b1, 1'b1, 1'b0, 16'd1, 10'd0,
                                       10'd1023), 1'b1, 24'h7F7F7F});
        // zero line height acts as one; y mirror flag ignored on x sides
        stim_rows.push_back('{mk_shade(3'd0, 16'h0000, 1'b0, 1'b0, 1'b1, 16'd0, 10'd0,
                                       10'd512), 1'b1, 24'hFFFFFF});
        // last texel of the last texture: row saturates high
        stim_rows.push_back('{mk_shade(3'd7, 16'hFFFF, 1'b0, 1'b0, 1'b0, 16'd1, 10'd1023,
                                       10'd1023), 1'b1, 24'h000000});
        // mirrored column on both kinds of side
        stim_rows.push_back('{mk_shade(3'd1, 16'h0000, 1'b0, 1'b1, 1'b0, 16'd1, 10'd0,
                                       10'd7), 1'b1, 24'hABCDEF});
        stim_rows.push_back('{mk_shade(3'd1, 16'h0000, 1'b1, 1'b0, 1'b1, 16'd1, 10'd0,
                                       10'd8), 1'b1, 24'h556677});
        stim_rows.push_back('{mk_shade(3'd7, 16'hFFFF, 1'b1, 1'b1, 1'b1, 16'd1, 10'd1023,
                                       10'd9), 1'b0, '0});
        // centre of a full-screen slice
        stim_rows.push_back('{mk_shade(3'd3, 16'h8000, 1'b0, 1'b0, 1'b0, 16'd480, 10'd240,
                                       10'd100), 1'b0, '0});
        // tallest slice, top and bottom row
        stim_rows.push_back('{mk_shade(3'd2, 16'h1234, 1'b0, 1'b1, 1'b0, 16'hFFFF, 10'd0,
                                       10'd200), 1'b0, '0});
        stim_rows.push_back('{mk_shade(3'd5, 16'hFFFF, 1'b1, 1'b1, 1'b0, 16'hFFFF, 10'd1023,
                                       10'd201), 1'b0, '0});
        // tiny slices around the screen centre: rounding and negative numerator
        stim_rows.push_back('{mk_shade(3'd4, 16'h5555, 1'b0, 1'b0, 1'b0, 16'd3, 10'd239,
                                       10'd300), 1'b0, '0});
        stim_rows.push_back('{mk_shade(3'd4, 16'hAAAA, 1'b1, 1'b0, 1'b0, 16'd3, 10'd238,
                                       10'd301), 1'b0, '0});
        stim_rows.push_back('{mk_shade(3'd6, 16'h7FFF, 1'b0, 1'b1, 1'b1, 16'd2, 10'd239,
                                       10'd302), 1'b0, '0});

        foreach (stim_rows[i]) begin
            issue(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].color);
        end
        drain();

        // random traffic under a run of geometries
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       begin gw = 10'd1;    gh = 10'd1;    gsh = 10'd1;    end
                1:       begin gw = 10'd0;    gh = 10'd0;    gsh = 10'd1023; end
                2:       begin gw = 10'd127;  gh = 10'd127;  gsh = 10'd0;    end
                3:       begin gw = 10'h3C5;  gh = 10'h2A0;  gsh = 10'd240;  end
                4:       begin gw = 10'd37;   gh = 10'd13;   gsh = 10'd600;  end
                5:       begin gw = 10'd64;   gh = 10'd64;   gsh = 10'd480;  end
                default: begin
                    gw  = 10'($urandom);
                    gh  = 10'($urandom);
                    gsh = 10'($urandom);
                end
            endcase
            set_geometry(gw, gh, gsh, ph == 3);
            // every third phase runs without request-side idling
            src_mode = (ph % 3 == 1) ? 0 : 1;
            for (int k = 0; k < BEATS_PER_PHASE; k++) begin
                random_beat();
                // mid-phase stop until the pipeline has emptied
                if (ph == 4 && k == BEATS_PER_PHASE / 2) begin
                    drain();
                end
            end
            drain();
        end

        if (pending_pixels.size() != 0) begin
            note_mismatch($sformatf("%0d pixels never came out", pending_pixels.size()));
        end

        $display("raycast_wall_texel_shader_tb: %0d loads, %0d shades (%0d on y sides)",
                 n_loads, n_shades, n_dark);
        $display({"raycast_wall_texel_shader_tb: %0d pixels checked over %0d geometries,",
                  " %0d mismatches"}, n_pixels, n_geometries + 1, errors);
        if (errors == 0) begin
            $display("raycast_wall_texel_shader_tb: done, clean");
        end else begin
            $display("raycast_wall_texel_shader_tb: done, errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/rwts_pkg.sv
rtl/rwts_in_if.sv
rtl/rwts_out_if.sv
rtl/rwts_cfg_if.sv
rtl/rwts_ram.sv
rtl/rwts_front.sv
rtl/rwts_div.sv
rtl/rwts_back.sv
rtl/raycast_wall_texel_shader.sv
dv/raycast_wall_texel_shader_tb.sv
